### rtl/rrbs_pkg.sv
// Shared types and defaults for the round-robin burst scheduler.
package rrbs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ID_BITS_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int STATUS_W       = 3;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_RAN      = 3'd1,
    ST_FINISHED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_ZERO     = 3'd5
  } status_t;

  // Per-cell control: shift takes the upper neighbor, load takes the load bus.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### rtl/round_robin_burst_scheduler.sv
// Round-robin burst scheduler: top level with the job chain and result register.
//
// Jobs sit in a chain of DEPTH cells, oldest in cell 0. An enqueue transaction
// (in_tuser = 0) loads the job into the first free cell; a tick transaction
// (in_tuser = 1) runs the job in cell 0, shifts every cell down by one and,
// unless the job has no bursts left, loads it back into the last occupied
// cell. Each input transaction yields exactly one result transaction in the next
// cycle; one transaction is taken per cycle, and the single output register
// is the only limit: input is held off only while a result waits on a low
// out_tready. Rejected items (empty tick, full ring, zero bursts) leave the
// chain untouched. The chain needs no clearing after reset: only occupied
// cells are ever read.
module round_robin_burst_scheduler import rrbs_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int OCC_W       = $clog2(DEPTH + 1),
  localparam int IDX_W       = $clog2(DEPTH),
  localparam int IN_TDATA_W  = ((ID_BITS + COUNT_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((ID_BITS + COUNT_BITS + OCC_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // job_id, burst_count, zero pad
  input  logic                   in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // run_id, bursts_left, occupancy, zero pad
  output logic [STATUS_W-1:0]    out_tuser   // status
);

  // Chain contents.
  logic [ID_BITS-1:0]    cell_id  [DEPTH];
  logic [COUNT_BITS-1:0] cell_cnt [DEPTH];
  cell_ctrl_t            cell_ctrl [DEPTH];

  // Control state.
  logic [OCC_W-1:0] job_cnt_r, job_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Result register (payload, no reset).
  status_t               out_status_r, out_status_nxt;
  logic [ID_BITS-1:0]    out_id_r,     out_id_nxt;
  logic [COUNT_BITS-1:0] out_left_r,   out_left_nxt;
  logic [OCC_W-1:0]      out_occ_r,    out_occ_nxt;

  logic                  accept;
  logic [ID_BITS-1:0]    in_id;
  logic [COUNT_BITS-1:0] in_cnt;
  logic [COUNT_BITS-1:0] head_left;
  logic                  chain_shift;
  logic                  chain_load;
  logic [OCC_W-1:0]      load_pos;
  logic [IDX_W-1:0]      load_idx;
  logic [ID_BITS-1:0]    load_id;
  logic [COUNT_BITS-1:0] load_cnt;

  assign in_id  = in_tdata[ID_BITS-1:0];
  assign in_cnt = in_tdata[ID_BITS +: COUNT_BITS];

  // Take a new transaction whenever the result slot is free or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign head_left = cell_cnt[0] - COUNT_BITS'(1);
  assign load_idx  = load_pos[IDX_W-1:0];

  always_comb begin
    job_cnt_nxt    = job_cnt_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_left_nxt   = out_left_r;
    out_occ_nxt    = out_occ_r;
    chain_shift    = 1'b0;
    chain_load     = 1'b0;
    load_pos       = job_cnt_r;
    load_id        = in_id;
    load_cnt       = in_cnt;

    if (accept) begin
      out_id_nxt   = '0;
      out_left_nxt = '0;
      unique case (op_t'(in_tuser))
        OP_ENQUEUE: begin
          if (job_cnt_r == OCC_W'(DEPTH)) begin
            out_status_nxt = ST_FULL;
          end else if (in_cnt == '0) begin
            out_status_nxt = ST_ZERO;
          end else begin
            // Append at the first free cell.
            chain_load     = 1'b1;
            job_cnt_nxt    = job_cnt_r + OCC_W'(1);
            out_status_nxt = ST_ENQUEUED;
            out_id_nxt     = in_id;
            out_left_nxt   = in_cnt;
          end
        end
        OP_TICK: begin
          if (job_cnt_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            // Pop the head; put it back at the tail if bursts remain.
            chain_shift = 1'b1;
            out_id_nxt  = cell_id[0];
            if (head_left == '0) begin
              job_cnt_nxt    = job_cnt_r - OCC_W'(1);
              out_status_nxt = ST_FINISHED;
            end else begin
              chain_load     = 1'b1;
              load_pos       = job_cnt_r - OCC_W'(1);
              load_id        = cell_id[0];
              load_cnt       = head_left;
              out_status_nxt = ST_RAN;
              out_left_nxt   = head_left;
            end
          end
        end
        default: begin
          out_status_nxt = ST_EMPTY;
        end
      endcase
      out_occ_nxt = job_cnt_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Cell chain: each cell takes its upper neighbor on a shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]    nbr_id;
    logic [COUNT_BITS-1:0] nbr_cnt;

    if (i == DEPTH - 1) begin : g_top
      assign nbr_id  = '0;
      assign nbr_cnt = '0;
    end else begin : g_mid
      assign nbr_id  = cell_id[i+1];
      assign nbr_cnt = cell_cnt[i+1];
    end

    assign cell_ctrl[i].shift = chain_shift;
    assign cell_ctrl[i].load  = chain_load && (load_idx == IDX_W'(i));

    rrbs_cell #(
      .ID_BITS   (ID_BITS),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[i]),
      .load_id (load_id),
      .load_cnt(load_cnt),
      .nbr_id  (nbr_id),
      .nbr_cnt (nbr_cnt),
      .id      (cell_id[i]),
      .cnt     (cell_cnt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_cnt_r   <= job_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_left_r   <= out_left_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({out_occ_r, out_left_r, out_id_r});

endmodule

### rtl/rrbs_cell.sv
// One job slot of the scheduler chain: holds an id and a burst count.
module rrbs_cell import rrbs_pkg::*; #(
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [ID_BITS-1:0]    load_id,
  input  logic [COUNT_BITS-1:0] load_cnt,
  input  logic [ID_BITS-1:0]    nbr_id,
  input  logic [COUNT_BITS-1:0] nbr_cnt,
  output logic [ID_BITS-1:0]    id,
  output logic [COUNT_BITS-1:0] cnt
);

  logic [ID_BITS-1:0]    id_r,  id_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  // Load wins over shift: the rotated head lands in the slot that shifts.
  always_comb begin
    id_nxt  = id_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      id_nxt  = load_id;
      cnt_nxt = load_cnt;
    end else if (ctrl.shift) begin
      id_nxt  = nbr_id;
      cnt_nxt = nbr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cnt_r <= cnt_nxt;
  end

  assign id  = id_r;
  assign cnt = cnt_r;

endmodule

### rtl/rrbs_checker.sv
// Port-level checks for the round-robin burst scheduler, bound to the top level.
module rrbs_checker import rrbs_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int OCC_W       = $clog2(DEPTH + 1),
  localparam int OUT_TDATA_W = ((ID_BITS + COUNT_BITS + OCC_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  logic [ID_BITS+COUNT_BITS-1:0] res_job;
  logic [OCC_W-1:0]              res_occ;

  assign res_job = out_tdata[ID_BITS+COUNT_BITS-1:0];
  assign res_occ = out_tdata[ID_BITS+COUNT_BITS +: OCC_W];

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Every accepted transaction produces a result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction without result");

  // Drop no result: input is held off while a result is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // An empty tick reports an empty ring and no job.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> (res_occ == '0) && (res_job == '0))
    else $error("empty result with jobs or job fields");

  // A full rejection reports a full ring.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (res_occ == OCC_W'(DEPTH)) && (res_job == '0))
    else $error("full rejection without full ring");

endmodule

bind round_robin_burst_scheduler rrbs_checker #(
  .DEPTH     (DEPTH),
  .ID_BITS   (ID_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_rrbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

### sim/tb_round_robin_burst_scheduler.sv
// Testbench for the round-robin burst scheduler: random stream traffic against a job-ring mirror.
`timescale 1ns / 1ps

module tb_round_robin_burst_scheduler;
  import rrbs_pkg::*;

  // Block geometry at its defaults; tdata fields are packed from bit 0 up.
  localparam int SLOTS     = DEPTH_DEF;
  localparam int ID_W      = ID_BITS_DEF;
  localparam int COUNT_W   = COUNT_BITS_DEF;
  localparam int OCC_W     = $clog2(SLOTS + 1);
  localparam int IN_W      = ((ID_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_W     = ((ID_W + COUNT_W + OCC_W + 7) / 8) * 8;
  localparam int LEFT_LSB  = ID_W;
  localparam int OCC_LSB   = ID_W + COUNT_W;
  localparam int RANDOM_CMDS = 1600;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  // Idle styles for either side: none, occasional, uniform.
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  typedef struct {
    op_t              op;
    logic [ID_W-1:0]  job_id;
    logic [COUNT_W-1:0] bursts;
    int unsigned      gap;    // idle cycles before this transaction is offered
    bit               drain;  // hold until every outstanding result is back
  } job_cmd_t;

  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    run_id;
    logic [COUNT_W-1:0] left;
    logic [OCC_W-1:0]   occ;
  } job_outcome_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata   = '0;   // job_id, burst_count
  logic                in_tuser   = 1'b0; // op
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;         // run_id, bursts_left, occupancy, zero pad
  logic [STATUS_W-1:0] out_tuser;         // status

  round_robin_burst_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Job-ring mirror: ids and remaining bursts per slot, head, tail and count.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]    mirror_id   [SLOTS];
  logic [COUNT_W-1:0] mirror_left [SLOTS];
  int                 mirror_head = 0;
  int                 mirror_tail = 0;
  int                 mirror_jobs = 0;

  // Apply one transaction to the mirror and return the result it must produce.
  function automatic job_outcome_t advance_mirror(op_t op, logic [ID_W-1:0] id,
                                                  logic [COUNT_W-1:0] cnt);
    job_outcome_t       r;
    int                 h;
    logic [COUNT_W-1:0] left;
    r.status = ST_EMPTY;
    r.run_id = '0;
    r.left   = '0;
    if (op == OP_ENQUEUE) begin
      // A full ring wins over a zero burst count.
      if (mirror_jobs >= SLOTS) begin
        r.status = ST_FULL;
      end else if (cnt == '0) begin
        r.status = ST_ZERO;
      end else begin
        mirror_id[mirror_tail]   = id;
        mirror_left[mirror_tail] = cnt;
        mirror_tail = (mirror_tail + 1) % SLOTS;
        mirror_jobs++;
        r.status = ST_ENQUEUED;
        r.run_id = id;
        r.left   = cnt;
      end
    end else if (mirror_jobs != 0) begin
      h           = mirror_head;
      r.run_id    = mirror_id[h];
      left        = mirror_left[h] - 1'b1;
      mirror_head = (h + 1) % SLOTS;
      if (left == '0) begin
        // Retire the job.
        mirror_jobs--;
        r.status = ST_FINISHED;
      end else begin
        // Rotate to the tail; on a full ring the tail is the old head slot.
        mirror_id[mirror_tail]   = r.run_id;
        mirror_left[mirror_tail] = left;
        mirror_tail = (mirror_tail + 1) % SLOTS;
        r.status = ST_RAN;
        r.left   = left;
      end
    end
    r.occ = OCC_W'(mirror_jobs);
    return r;
  endfunction

  function automatic int unsigned draw_idle(int style);
    if (style == IDLE_NONE) return 0;
    if (style == IDLE_LIGHT) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    return $urandom_range(0, 18);
  endfunction

  // Mostly short jobs so they retire and the ring keeps cycling through
  // empty and full; a few zero counts and a few longer jobs.
  function automatic logic [COUNT_W-1:0] draw_bursts();
    int unsigned k;
    k = $urandom_range(0, 49);
    if (k < 3) return '0;
    if (k == 3) return COUNT_W'($urandom_range(7, 40));
    return COUNT_W'($urandom_range(1, 6));
  endfunction

  // ---------------------------------------------------------------------------
  // Command queue, filled once at time zero and drained by the driver.
  // ---------------------------------------------------------------------------
  job_cmd_t job_cmd_q[$];
  int       src_style = IDLE_LIGHT;

  function automatic void add_cmd(op_t op, logic [ID_W-1:0] id, logic [COUNT_W-1:0] cnt,
                                  bit drain);
    job_cmd_t c;
    c.op     = op;
    c.job_id = id;
    c.bursts = cnt;
    c.gap    = draw_idle(src_style);
    c.drain  = drain;
    job_cmd_q.push_back(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the next command after its gap; hold it until accepted.
  // ---------------------------------------------------------------------------
  int unsigned hold_cycles = 0;
  int          accepted_cnt = 0;  // updated nonblocking by the monitor
  int          returned_cnt = 0;  // updated nonblocking by the monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      hold_cycles = 0;
    end else if (!in_tvalid || in_tready) begin
      if (job_cmd_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (hold_cycles < job_cmd_q[0].gap) begin
        hold_cycles++;
        in_tvalid <= 1'b0;
      end else if (job_cmd_q[0].drain && (in_tvalid || accepted_cnt != returned_cnt)) begin
        // Hold until the block has handed back every result.
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid   <= 1'b1;
        in_tuser    <= job_cmd_q[0].op;
        in_tdata    <= {job_cmd_q[0].bursts, job_cmd_q[0].job_id};
        hold_cycles = 0;
        void'(job_cmd_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: after each taken result, stall for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  int unsigned stall_cycles = 0;
  int          sink_style   = IDLE_NONE;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stall_cycles = 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 39) == 0) sink_style = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      stall_cycles = draw_idle(sink_style);
      out_tready <= (stall_cycles == 0);
    end else if (!out_tready) begin
      if (stall_cycles > 0) stall_cycles--;
      if (stall_cycles == 0) out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation, then predict
  // the result of any transaction accepted at this edge.
  // ---------------------------------------------------------------------------
  job_outcome_t outcome_q[$];
  int           error_cnt    = 0;
  int           mismatch_cnt = 0;
  int           enqueue_cnt  = 0;
  int           tick_cnt     = 0;
  int           status_hits[6] = '{default: 0};

  always @(posedge clk) begin
    job_outcome_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        returned_cnt <= returned_cnt + 1;
        if (outcome_q.size() == 0) begin
          error_cnt++;
          if (mismatch_cnt < MAX_REPORTS)
            $display("[%0t] unexpected result: status %0d data %h", $time, out_tuser, out_tdata);
          mismatch_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (out_tuser !== want.status ||
              out_tdata[0 +: ID_W] !== want.run_id ||
              out_tdata[LEFT_LSB +: COUNT_W] !== want.left ||
              out_tdata[OCC_LSB +: OCC_W] !== want.occ) begin
            error_cnt++;
            if (mismatch_cnt < MAX_REPORTS)
              $display({"[%0t] mismatch: expected status %0d id %h left %h occ %0d,",
                        " got status %0d id %h left %h occ %0d"},
                       $time, want.status, want.run_id, want.left, want.occ, out_tuser,
                       out_tdata[0 +: ID_W], out_tdata[LEFT_LSB +: COUNT_W],
                       out_tdata[OCC_LSB +: OCC_W]);
            mismatch_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        accepted_cnt <= accepted_cnt + 1;
        if (op_t'(in_tuser) == OP_ENQUEUE) enqueue_cnt++;
        else tick_cnt++;
        want = advance_mirror(op_t'(in_tuser), in_tdata[0 +: ID_W],
                              in_tdata[ID_W +: COUNT_W]);
        status_hits[want.status]++;
        outcome_q.push_back(want);
      end
    end
  end

  // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outcome_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int fill_bias;

    // Directed: empty tick, zero bursts, extreme fields, retire and rotate.
    add_cmd(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0);      // tick on an empty ring
    add_cmd(OP_ENQUEUE, 16'h1234, 16'h0000, 1'b0);   // zero bursts rejected
    add_cmd(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 1'b0);   // all ones
    add_cmd(OP_ENQUEUE, 16'h0000, 16'h0001, 1'b0);   // all zeros id, single burst
    add_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0);      // run and rotate
    add_cmd(OP_TICK, 16'hA5A5, 16'h5A5A, 1'b0);      // run and retire
    for (int i = 0; i < SLOTS - 1; i++)
      add_cmd(OP_ENQUEUE, ID_W'(16'h1000 + i), COUNT_W'(1 + i % 3), 1'b0);
    add_cmd(OP_ENQUEUE, 16'hBEEF, 16'h0007, 1'b0);   // full ring rejected
    add_cmd(OP_ENQUEUE, 16'hCAFE, 16'h0000, 1'b0);   // full wins over zero bursts
    add_cmd(OP_TICK, 16'h0000, 16'h0000, 1'b0);      // rotation of a full ring

    // Random: alternate fill, drain and balanced phases with random content.
    fill_bias = 50;
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % 40 == 0) fill_bias = 25 * $urandom_range(1, 3);
      if (i % 60 == 0) src_style = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      if ($urandom_range(1, 100) <= fill_bias)
        add_cmd(OP_ENQUEUE, ID_W'($urandom), draw_bursts(), i % 400 == 0);
      else
        add_cmd(OP_TICK, ID_W'($urandom), COUNT_W'($urandom), i % 400 == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last transaction to go in and every result to come back.
    do @(negedge clk); while (job_cmd_q.size() != 0 || in_tvalid);
    while (accepted_cnt != returned_cnt) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d transactions (%0d enqueues, %0d ticks), checked %0d results, %0d errors.",
             accepted_cnt, enqueue_cnt, tick_cnt, returned_cnt, error_cnt);
    $display("Outcomes: enqueued %0d, ran %0d, retired %0d, empty %0d, full %0d, zero %0d.",
             status_hits[ST_ENQUEUED], status_hits[ST_RAN], status_hits[ST_FINISHED],
             status_hits[ST_EMPTY], status_hits[ST_FULL], status_hits[ST_ZERO]);
    if (error_cnt == 0 && outcome_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rrbs_pkg.sv
rtl/rrbs_cell.sv
rtl/round_robin_burst_scheduler.sv
rtl/rrbs_checker.sv
sim/tb_round_robin_burst_scheduler.sv
